### sv/cba_pkg.sv
// Shared types, constants and helpers for the circuit breaker admission block.
package cba_pkg;

    localparam int CBA_TIME_W = 48;
    localparam int CBA_CNT_W  = 32;
    localparam int CBA_LIM_W  = 16;
    localparam int CBA_TMO_W  = 32;
    localparam int CBA_ADDR_W = 4;
    localparam int CBA_DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_REQUEST = 2'd0,
        ACT_SUCCESS = 2'd1,
        ACT_FAILURE = 2'd2,
        ACT_RESET   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_CLOSED = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_HALF   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        REG_FAILURE_LIMIT = 2'd0,
        REG_SUCCESS_LIMIT = 2'd1,
        REG_PROBE_LIMIT   = 2'd2,
        REG_OPEN_TIMEOUT  = 2'd3
    } t_reg;

    localparam logic [CBA_LIM_W-1:0] RST_FAILURE_LIMIT = 16'd5;
    localparam logic [CBA_LIM_W-1:0] RST_SUCCESS_LIMIT = 16'd3;
    localparam logic [CBA_LIM_W-1:0] RST_PROBE_LIMIT   = 16'd3;
    localparam logic [CBA_TMO_W-1:0] RST_OPEN_TIMEOUT  = 32'd30000;

    typedef struct packed {
        logic [CBA_LIM_W-1:0] failure_limit;
        logic [CBA_LIM_W-1:0] success_limit;
        logic [CBA_LIM_W-1:0] probe_limit;
        logic [CBA_TMO_W-1:0] open_timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_action               action;
        logic [CBA_TIME_W-1:0] now_ms;
    } t_evt;

    function automatic logic [CBA_LIM_W-1:0] sat_inc16(input logic [CBA_LIM_W-1:0] v);
        return (v == {CBA_LIM_W{1'b1}}) ? v : v + {{(CBA_LIM_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

### sv/cba_if.sv
// Event and result channel interfaces.
interface cba_evt_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     action;
    logic [cba_pkg::CBA_TIME_W-1:0] now_ms;

    modport source (output valid, action, now_ms, input ready);
    modport sink   (input valid, action, now_ms, output ready);
endinterface

interface cba_res_if;
    logic                          valid;
    logic                          ready;
    logic                          admitted;
    logic [1:0]                    breaker_mode;
    logic [cba_pkg::CBA_CNT_W-1:0] success_total;
    logic [cba_pkg::CBA_CNT_W-1:0] failure_total;
    logic [cba_pkg::CBA_CNT_W-1:0] rejected_total;

    modport source (output valid, admitted, breaker_mode, success_total, failure_total,
                    rejected_total, input ready);
    modport sink   (input valid, admitted, breaker_mode, success_total, failure_total,
                    rejected_total, output ready);
endinterface

### sv/cba_cfg.sv
// APB-style configuration register file for the breaker limits and timeout.
module cba_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cba_pkg::CBA_ADDR_W-1:0] paddr,
    input  logic [cba_pkg::CBA_DATA_W-1:0] pwdata,
    output logic [cba_pkg::CBA_DATA_W-1:0] prdata,
    output logic                           pready,
    output cba_pkg::t_cfg                  o_cfg
);
    import cba_pkg::*;

    t_cfg r_cfg;
    t_reg reg_sel;
    logic wr_en;

    assign reg_sel = t_reg'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.failure_limit   <= RST_FAILURE_LIMIT;
            r_cfg.success_limit   <= RST_SUCCESS_LIMIT;
            r_cfg.probe_limit     <= RST_PROBE_LIMIT;
            r_cfg.open_timeout_ms <= RST_OPEN_TIMEOUT;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_FAILURE_LIMIT: r_cfg.failure_limit   <= pwdata[CBA_LIM_W-1:0];
                REG_SUCCESS_LIMIT: r_cfg.success_limit   <= pwdata[CBA_LIM_W-1:0];
                REG_PROBE_LIMIT:   r_cfg.probe_limit     <= pwdata[CBA_LIM_W-1:0];
                REG_OPEN_TIMEOUT:  r_cfg.open_timeout_ms <= pwdata[CBA_TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FAILURE_LIMIT: prdata = {{(CBA_DATA_W-CBA_LIM_W){1'b0}}, r_cfg.failure_limit};
            REG_SUCCESS_LIMIT: prdata = {{(CBA_DATA_W-CBA_LIM_W){1'b0}}, r_cfg.success_limit};
            REG_PROBE_LIMIT:   prdata = {{(CBA_DATA_W-CBA_LIM_W){1'b0}}, r_cfg.probe_limit};
            REG_OPEN_TIMEOUT:  prdata = r_cfg.open_timeout_ms;
            default:           prdata = '0;
        endcase
    end

endmodule

### sv/cba_in_stage.sv
// Input register for event words.
module cba_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cba_evt_if.sink       i_evt,
    input  logic          i_take,
    output logic          o_valid,
    output cba_pkg::t_evt o_evt
);
    import cba_pkg::*;

    logic r_valid;
    logic n_valid;
    t_evt r_evt;
    logic accept;

    assign i_evt.ready = !r_valid || i_take;
    assign accept      = i_evt.valid && i_evt.ready;
    assign o_valid     = r_valid;
    assign o_evt       = r_evt;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_evt.action <= t_action'(i_evt.action);
            r_evt.now_ms <= i_evt.now_ms;
        end
    end

endmodule

### sv/cba_core.sv
// Breaker state, per-event update and result register.
module cba_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cba_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  cba_pkg::t_evt i_evt,
    output logic          o_take,
    cba_res_if.source     o_res
);
    import cba_pkg::*;

    t_mode                 r_mode,   n_mode;
    logic [CBA_LIM_W-1:0]  r_cf,     n_cf;
    logic [CBA_LIM_W-1:0]  r_ps,     n_ps;
    logic [CBA_LIM_W-1:0]  r_pa,     n_pa;
    logic [CBA_TIME_W-1:0] r_opened, n_opened;
    logic [CBA_CNT_W-1:0]  r_succ,   n_succ;
    logic [CBA_CNT_W-1:0]  r_fail,   n_fail;
    logic [CBA_CNT_W-1:0]  r_rej,    n_rej;

    logic                  r_out_valid;
    logic                  r_out_admitted;
    t_mode                 r_out_mode;

    logic                  n_admitted;
    logic                  advance;
    logic [CBA_TIME_W-1:0] elapsed;
    logic                  timeout_hit;
    logic [CBA_LIM_W-1:0]  ps_inc;
    logic [CBA_LIM_W-1:0]  cf_inc;

    assign o_take  = !r_out_valid || o_res.ready;
    assign advance = i_valid && o_take;

    assign elapsed     = i_evt.now_ms - r_opened;
    assign timeout_hit = (i_evt.now_ms > r_opened)
                       ? (elapsed >= {{(CBA_TIME_W-CBA_TMO_W){1'b0}}, i_cfg.open_timeout_ms})
                       : (i_cfg.open_timeout_ms == '0);
    assign ps_inc = sat_inc16(r_ps);
    assign cf_inc = sat_inc16(r_cf);

    always_comb begin
        n_mode     = r_mode;
        n_cf       = r_cf;
        n_ps       = r_ps;
        n_pa       = r_pa;
        n_opened   = r_opened;
        n_succ     = r_succ;
        n_fail     = r_fail;
        n_rej      = r_rej;
        n_admitted = 1'b0;
        case (i_evt.action)
            ACT_REQUEST: begin
                case (r_mode)
                    MODE_CLOSED: n_admitted = 1'b1;
                    MODE_OPEN: begin
                        if (timeout_hit) begin
                            n_mode     = MODE_HALF;
                            n_ps       = '0;
                            n_pa       = {{(CBA_LIM_W-1){1'b0}}, 1'b1};
                            n_admitted = 1'b1;
                        end else begin
                            n_rej = r_rej + 1'b1;
                        end
                    end
                    MODE_HALF: begin
                        if (r_pa >= i_cfg.probe_limit) begin
                            n_rej = r_rej + 1'b1;
                        end else begin
                            n_pa       = sat_inc16(r_pa);
                            n_admitted = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_SUCCESS: begin
                n_succ = r_succ + 1'b1;
                case (r_mode)
                    MODE_CLOSED: n_cf = '0;
                    MODE_HALF: begin
                        n_ps = ps_inc;
                        if (ps_inc >= i_cfg.success_limit) begin
                            n_mode = MODE_CLOSED;
                            n_cf   = '0;
                            n_pa   = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_FAILURE: begin
                n_fail = r_fail + 1'b1;
                case (r_mode)
                    MODE_CLOSED: begin
                        n_cf = cf_inc;
                        if (cf_inc >= i_cfg.failure_limit) begin
                            n_mode   = MODE_OPEN;
                            n_opened = i_evt.now_ms;
                            n_pa     = '0;
                        end
                    end
                    MODE_HALF: begin
                        n_mode   = MODE_OPEN;
                        n_opened = i_evt.now_ms;
                        n_pa     = '0;
                    end
                    default: ;
                endcase
            end
            ACT_RESET: begin
                n_mode = MODE_CLOSED;
                n_cf   = '0;
                n_ps   = '0;
                n_pa   = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_CLOSED;
            r_cf        <= '0;
            r_ps        <= '0;
            r_pa        <= '0;
            r_opened    <= '0;
            r_succ      <= '0;
            r_fail      <= '0;
            r_rej       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_mode   <= n_mode;
                r_cf     <= n_cf;
                r_ps     <= n_ps;
                r_pa     <= n_pa;
                r_opened <= n_opened;
                r_succ   <= n_succ;
                r_fail   <= n_fail;
                r_rej    <= n_rej;
            end
            if (o_take) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_admitted <= n_admitted;
            r_out_mode     <= n_mode;
        end
    end

    // totals in the result word are the committed counters
    assign o_res.valid          = r_out_valid;
    assign o_res.admitted       = r_out_admitted;
    assign o_res.breaker_mode   = r_out_mode;
    assign o_res.success_total  = r_succ;
    assign o_res.failure_total  = r_fail;
    assign o_res.rejected_total = r_rej;

`ifndef SYNTHESIS
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res.ready |=> $stable(r_mode) && $stable(r_rej))
        else $error("breaker state changed while result word stalled");

    a_reset_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && i_evt.action == ACT_RESET |=> r_mode == MODE_CLOSED && r_cf == '0)
        else $error("reset event did not close the breaker");

    a_no_admit_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_admitted |-> r_out_mode != MODE_OPEN)
        else $error("request admitted while breaker left open");

    a_closed_no_probes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_CLOSED |-> r_pa == '0)
        else $error("probe count nonzero in closed mode");
`endif

endmodule

### sv/circuit_breaker_admission.sv
// An accepted word waits in the input register until the core takes it into the result register.
// Throughput: one event word per cycle while the result word is not stalled.
// A stalled result word holds the input register, which still takes one word.
// Reset (synchronous, active low) closes the breaker, clears all counters and
// restores the limits to 5 failures, 3 successes, 3 probes and a 30000 ms timeout.
module circuit_breaker_admission (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cba_evt_if.sink                        i_evt,
    cba_res_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cba_pkg::CBA_ADDR_W-1:0] paddr,
    input  logic [cba_pkg::CBA_DATA_W-1:0] pwdata,
    output logic [cba_pkg::CBA_DATA_W-1:0] prdata,
    output logic                           pready
);
    import cba_pkg::*;

    t_cfg cfg;
    t_evt evt;
    logic evt_valid;
    logic take;

    cba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cba_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (i_evt),
        .i_take  (take),
        .o_valid (evt_valid),
        .o_evt   (evt)
    );

    cba_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (evt_valid),
        .i_evt   (evt),
        .o_take  (take),
        .o_res   (o_res)
    );

endmodule
